// ===== rtl/core/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types for the UTF-8 stream decoder: beat payloads and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    // Input beat: one byte of encoded text
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    // Output beat: one code point (or raw byte value)
    typedef struct packed {
        logic [20:0] code_point;
        logic        last_in_run;
        logic        text_done;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic take_byte;   // absorb a byte that does not end the text
        logic load_flush;  // absorb the final byte and load the flush buffer
        logic flush_emit;  // decode one code point from the flush buffer
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic flush_last;  // current flush decode is the final result
    } t_dp_sts;

endpackage

// ===== rtl/core/u8sd_dp.sv =====
// ----------------------------------------------------------------------------
// u8sd_dp
// Datapath: pending byte buffer, sequence length tracking, code point decode
// for a completed sequence and for the flush buffer, the flush position
// counter and the output register.
// ----------------------------------------------------------------------------
module u8sd_dp
    import u8sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [7:0] i_byte,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef logic [3:0][7:0] t_byte_buf;

    typedef struct packed {
        logic [20:0] cp;
        logic [3:0]  npos;
    } t_dec;

    localparam logic [1:0] FlushMaxIdx = 2'd2;

    // Sequence length announced by a lead byte, zero when it is no lead
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] n;
        n = 3'd0;
        if      ((c & 8'hE0) == 8'hC0) n = 3'd2;
        else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
        return n;
    endfunction

    // Decode one code point at pos; a stray or cut-short lead goes out raw
    function automatic t_dec decode_at(input t_byte_buf b, input logic [2:0] len,
                                       input logic [2:0] pos);
        t_dec       d;
        logic [7:0] c;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] n;
        c  = b[pos[1:0]];
        b1 = b[pos[1:0] + 2'd1];
        b2 = b[pos[1:0] + 2'd2];
        b3 = b[pos[1:0] + 2'd3];
        n  = lead_len(c);
        if (n == 3'd0 || ({1'b0, pos} + {1'b0, n}) > {1'b0, len}) begin
            d.cp   = {13'd0, c};
            d.npos = {1'b0, pos} + 4'd1;
        end else begin
            case (n)
                3'd2:    d.cp = {10'd0, c[4:0], b1[5:0]};
                3'd3:    d.cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
                default: d.cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
            endcase
            d.npos = {1'b0, pos} + {1'b0, n};
        end
        return d;
    endfunction

    t_byte_buf  r_buf,  n_buf;
    logic [1:0] r_cnt,  n_cnt;
    logic [2:0] r_need, n_need;
    logic [2:0] r_len,  n_len;
    logic [2:0] r_pos,  n_pos;
    logic [1:0] r_nres, n_nres;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out,  n_out;

    t_byte_buf  tb;
    t_dec       dec_t;
    t_dec       dec_f;
    logic [2:0] byte_len;
    logic       flush_last;
    logic       out_free;

    // Decode paths: completed sequence during the run, and the flush buffer
    always_comb begin
        tb        = r_buf;
        tb[r_cnt] = i_byte;
        dec_t     = decode_at(tb, {1'b0, r_cnt} + 3'd1, 3'd0);
        dec_f     = decode_at(r_buf, r_len, r_pos);
        byte_len  = lead_len(i_byte);
        flush_last = (dec_f.npos >= {1'b0, r_len}) || (r_nres == FlushMaxIdx);
        out_free  = !r_out_valid || i_out_ready;
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.flush_last = flush_last;

    // Next state of buffer, counters and output register
    always_comb begin
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_need      = r_need;
        n_len       = r_len;
        n_pos       = r_pos;
        n_nres      = r_nres;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cmd.take_byte) begin
            if (r_cnt == 2'd0) begin
                if (byte_len == 3'd0) begin
                    n_out_valid      = 1'b1;
                    n_out.code_point = {13'd0, i_byte};
                    n_out.last_in_run = 1'b1;
                    n_out.text_done  = 1'b0;
                end else begin
                    n_buf[0] = i_byte;
                    n_cnt    = 2'd1;
                    n_need   = byte_len;
                end
            end else if (({1'b0, r_cnt} + 3'd1) >= r_need) begin
                n_out_valid       = 1'b1;
                n_out.code_point  = dec_t.cp;
                n_out.last_in_run = 1'b1;
                n_out.text_done   = 1'b0;
                n_cnt             = 2'd0;
                n_need            = 3'd0;
            end else begin
                n_buf[r_cnt] = i_byte;
                n_cnt        = r_cnt + 2'd1;
            end
        end

        if (i_cmd.load_flush) begin
            n_buf[r_cnt] = i_byte;
            n_len        = {1'b0, r_cnt} + 3'd1;
            n_pos        = 3'd0;
            n_nres       = 2'd0;
            n_cnt        = 2'd0;
            n_need       = 3'd0;
        end

        if (i_cmd.flush_emit) begin
            n_out_valid       = 1'b1;
            n_out.code_point  = dec_f.cp;
            n_out.last_in_run = flush_last;
            n_out.text_done   = flush_last;
            n_pos             = dec_f.npos[2:0];
            n_nres            = r_nres + 2'd1;
        end
    end

    // Hold control state under reset; payload registers run free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_need      <= 3'd0;
            r_len       <= 3'd0;
            r_pos       <= 3'd0;
            r_nres      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_need      <= n_need;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_nres      <= n_nres;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/u8sd_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8sd_ctrl
// Controller: accepts byte beats while idle and steps the datapath through
// the end-of-text flush, one result beat per step.
// ----------------------------------------------------------------------------
module u8sd_ctrl
    import u8sd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_end_of_text,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // Take a beat only when the output register has room
    always_comb begin
        o_in_ready       = (r_state == S_IDLE) && i_sts.out_free;
        accept           = i_in_valid && o_in_ready;
        o_cmd.take_byte  = accept && !i_end_of_text;
        o_cmd.load_flush = accept && i_end_of_text;
        o_cmd.flush_emit = (r_state == S_FLUSH) && i_sts.out_free;
    end

    // Advance into flush on the final byte, leave after its last result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load_flush) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (o_cmd.flush_emit && i_sts.flush_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one text byte per beat in, code points out.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+--------------------------
//   in      | sink      | t_in_item   | i_in_valid / o_in_ready
//   out     | source    | t_out_item  | o_out_valid / i_out_ready
//
// A byte without end-of-text is taken back to back while idle, whenever
// the single output register is empty or being drained.
// A final byte is buffered, then the flush gives 1 to 3 results, one per step:
// the flush decoder walks the four-byte flush buffer one code point a step.
// Reset clears the held count, sequence length and output valid; held bytes
// stay unknown until written. A stalled output holds both input and flush.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    u8sd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_text (i_in_data.end_of_text),
        .i_sts         (sts),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    u8sd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in_data.text_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/u8sd_chk.sv =====
// ----------------------------------------------------------------------------
// u8sd_chk
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8sd_chk
    import u8sd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // End of text always closes a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.text_done |-> o_out_data.last_in_run)
        else $error("text_done without last_in_run");

    // Mid-flush results block new input
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_in_run |-> !o_in_ready)
        else $error("input ready while flush results remain");

    // Drop the output beat on reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_stream_decoder u8sd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
